### rtl/nhkp_pkg.sv
// ----------------------------------------------------------------------------
// nhkp_pkg: shared types and constants of the nibble handshake keyboard poller
// Field widths, command and status codes, pin drive codes, the modifier
// scancode decoder and the input and result payload structs.
// ----------------------------------------------------------------------------
package nhkp_pkg;

  localparam int unsigned NIBBLE_COUNT_DEF = 12;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned SC_W     = 8;
  localparam int unsigned TMO_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DW   = 8;
  localparam int unsigned KEY_N    = 256;
  localparam int unsigned MOD_W    = 6;

  // Command codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DETECT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POLL   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 1'b1;

  localparam logic [TMO_W-1:0] TIMEOUT_RST = 8'd128;

  // Pin drive codes: bit 1 is TH, bit 0 is TR.
  localparam logic [1:0] DRV_NONE = 2'b00;
  localparam logic [1:0] DRV_TR   = 2'b01;
  localparam logic [1:0] DRV_BOTH = 2'b11;

  // Nibble positions inside one poll frame.
  localparam int unsigned NIB_SIG0  = 0;
  localparam int unsigned NIB_SIG1  = 1;
  localparam int unsigned NIB_STAT  = 7;
  localparam int unsigned NIB_SC_HI = 8;
  localparam int unsigned NIB_SC_LO = 9;

  localparam logic [NIB_W-1:0] SIG0_VAL     = 4'h3;
  localparam logic [NIB_W-1:0] SIG1_VAL     = 4'h4;
  localparam logic [NIB_W-1:0] EVENT_MASK   = 4'h9;
  localparam logic [NIB_W-1:0] KBD_ID_VAL   = 4'h1;

  // Modifier flag bits.
  localparam logic [MOD_W-1:0] MOD_LSHIFT = 6'h01;
  localparam logic [MOD_W-1:0] MOD_RSHIFT = 6'h02;
  localparam logic [MOD_W-1:0] MOD_LCTRL  = 6'h04;
  localparam logic [MOD_W-1:0] MOD_RCTRL  = 6'h08;
  localparam logic [MOD_W-1:0] MOD_LALT   = 6'h10;
  localparam logic [MOD_W-1:0] MOD_RALT   = 6'h20;

  typedef enum logic [1:0] {
    ST_COMM_ERROR = 2'd0,
    ST_NO_EVENT   = 2'd1,
    ST_KEY_EVENT  = 2'd2
  } status_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              tl_in;
    logic [NIB_W-1:0]  data_in;
    logic [SC_W-1:0]   query_scancode;
  } item_t;

  typedef struct packed {
    logic            th_out;
    logic            tr_out;
    logic            done_res;
    logic [1:0]      poll_status;
    logic            event_valid;
    logic [SC_W-1:0] event_scancode;
    logic            make_break;
    logic            key_pressed;
    logic            shift_held;
    logic            ctrl_held;
    logic            alt_held;
    logic            present;
  } result_t;

  // Maps a scancode to its modifier flag, or to zero for ordinary keys.
  function automatic logic [MOD_W-1:0] mod_mask(input logic [SC_W-1:0] sc);
    logic [MOD_W-1:0] m;
    case (sc)
      8'h12:   m = MOD_LSHIFT;
      8'h59:   m = MOD_RSHIFT;
      8'h14:   m = MOD_LCTRL;
      8'h18:   m = MOD_RCTRL;
      8'h11:   m = MOD_LALT;
      8'h17:   m = MOD_RALT;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

### rtl/nhkp_if.sv
// ----------------------------------------------------------------------------
// nhkp_if: valid/ready channels of the nibble handshake keyboard poller
// One interface for the sampled pin items and one for the result items.
// ----------------------------------------------------------------------------
interface nhkp_in_if;
  import nhkp_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic              tl_in;
  logic [NIB_W-1:0]  data_in;
  logic [SC_W-1:0]   query_scancode;

  modport source (output valid, mode, tl_in, data_in, query_scancode, input ready);
  modport sink (input valid, mode, tl_in, data_in, query_scancode, output ready);
endinterface

interface nhkp_out_if;
  import nhkp_pkg::*;
  logic            valid;
  logic            ready;
  logic            th_out;
  logic            tr_out;
  logic            done_res;
  logic [1:0]      poll_status;
  logic            event_valid;
  logic [SC_W-1:0] event_scancode;
  logic            make_break;
  logic            key_pressed;
  logic            shift_held;
  logic            ctrl_held;
  logic            alt_held;
  logic            present;

  modport source (output valid, th_out, tr_out, done_res, poll_status, event_valid,
                  event_scancode, make_break, key_pressed, shift_held, ctrl_held,
                  alt_held, present, input ready);
  modport sink (input valid, th_out, tr_out, done_res, poll_status, event_valid,
                event_scancode, make_break, key_pressed, shift_held, ctrl_held,
                alt_held, present, output ready);
endinterface

### rtl/nibble_handshake_keyboard_poller_unit.sv
// ----------------------------------------------------------------------------
// nibble_handshake_keyboard_poller_unit: host-side keyboard nibble poller
// Steps the detect and poll handshake once per sampled pin item and keeps the
// key map and modifier flags of the attached keyboard.
// ----------------------------------------------------------------------------
// Usage. Every transfer on in_ch is one sampled tick of the keyboard port: the
// command (plain tick, detect or poll), the TL level, the data nibble and a
// scancode to query. Every such transfer yields exactly one transfer on out_ch
// carrying the TH/TR levels to drive, the done flag, the stored poll status, a
// key event if one completed, the queried key state and the modifier flags.
// Configuration (handshake timeout and the make/break polarity) is written on
// the cfg_* port while no item is in flight.
// Pipeline: an accepted item is held in the input register, is stepped through
// the handshake state machine and lands in the result register, from which its
// result is offered on out_ch.
// One item is taken per cycle while the receiver does not stall.
// The key map is a 256 x 1 memory: its read is launched at the input transfer
// and a one-entry bypass covers a write made in that same cycle.
// Reset puts the state machine in idle with TH and TR high, clears the key
// map (per-entry valid bits), the modifier flags, the present flag and sets the
// status to communication error; no clearing pass is needed.
// When the receiver stalls, the result register holds and one further item may
// still be taken into the input register; after that in_ch.ready drops.
// ----------------------------------------------------------------------------
module nibble_handshake_keyboard_poller_unit #(
  parameter int unsigned NIBBLE_COUNT = nhkp_pkg::NIBBLE_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  nhkp_in_if.sink                        in_ch,
  nhkp_out_if.source                     out_ch,
  input  logic                           cfg_we_i,
  input  logic [nhkp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nhkp_pkg::CFG_DW-1:0]    cfg_data_i
);
  import nhkp_pkg::*;

  localparam int unsigned IDX_W = $clog2(NIBBLE_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NIBBLE_COUNT - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DETECT,
    PH_WAIT_LOW,
    PH_WAIT_HIGH
  } phase_e;

  // Configuration registers.
  logic [TMO_W-1:0] timeout_q;
  logic             polarity_q;

  // Pipeline: input register, result register.
  logic    a_vld_q;
  item_t   a_q;
  logic    o_vld_q;
  result_t res_q;
  logic    commit;
  logic    load;

  // Handshake state.
  phase_e           phase_q, phase_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [TMO_W-1:0] miss_q, miss_d;
  logic [NIB_W-1:0] nib_q [NIBBLE_COUNT];
  logic [MOD_W-1:0] mod_q, mod_d;
  logic             present_q, present_d;
  status_e          status_q, status_d;
  logic [1:0]       pin_q, pin_d;

  // Key map memory with per-entry valid bits and a one-entry write bypass.
  logic            key_mem [KEY_N];
  logic [KEY_N-1:0] key_vld_q;
  logic            rd_q;
  logic            byp_vld_q;
  logic [SC_W-1:0] byp_addr_q;
  logic            byp_bit_q;

  // Step results.
  logic [NIB_W-1:0] nib_cur [NIBBLE_COUNT];
  logic             nib_we;
  logic             clr_keys;
  logic             key_we;
  logic             key_bit;
  logic             done;
  logic             ev;
  logic             mb;
  logic [SC_W-1:0]  sc;
  logic             want;
  logic             down;
  logic [MOD_W-1:0] mmask;
  logic [NIB_W-1:0] n7;
  logic             frame_mb;
  logic [SC_W-1:0]  frame_sc;
  logic             key_base;
  result_t          res_d;

  assign commit      = a_vld_q && (!o_vld_q || out_ch.ready);
  assign in_ch.ready = !a_vld_q || commit;
  assign load        = in_ch.valid && in_ch.ready;

  // Even nibbles wait for TL low, odd ones for TL high; a nibble is captured
  // on the tick where TL matches.
  assign want   = (phase_q == PH_WAIT_HIGH);
  assign nib_we = (phase_q == PH_WAIT_LOW || phase_q == PH_WAIT_HIGH) &&
                  (a_q.tl_in == want);

  // Nibble store seen with the nibble captured on this tick forwarded in, so
  // the last nibble of a frame is usable at once.
  always_comb begin
    for (int i = 0; i < NIBBLE_COUNT; i++) begin
      nib_cur[i] = (nib_we && idx_q == IDX_W'(i)) ? a_q.data_in : nib_q[i];
    end
  end

  assign n7       = nib_cur[IDX_W'(NIB_STAT)];
  assign frame_mb = n7[0];
  assign frame_sc = {nib_cur[IDX_W'(NIB_SC_HI)], nib_cur[IDX_W'(NIB_SC_LO)]};
  assign mmask    = mod_mask(frame_sc);
  assign down     = (frame_mb == polarity_q);

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    miss_d    = miss_q;
    mod_d     = mod_q;
    present_d = present_q;
    status_d  = status_q;
    pin_d     = pin_q;
    clr_keys  = 1'b0;
    key_we    = 1'b0;
    key_bit   = 1'b0;
    done      = 1'b0;
    ev        = 1'b0;
    mb        = 1'b0;
    sc        = '0;
    case (phase_q)
      PH_IDLE: begin
        if (a_q.mode == MODE_DETECT) begin
          clr_keys = 1'b1;
          mod_d    = '0;
          pin_d    = DRV_TR;
          phase_d  = PH_DETECT;
        end else if (a_q.mode == MODE_POLL && present_q) begin
          idx_d   = '0;
          miss_d  = '0;
          pin_d   = DRV_NONE;
          phase_d = PH_WAIT_LOW;
        end
      end
      PH_DETECT: begin
        present_d = (a_q.data_in == KBD_ID_VAL);
        pin_d     = DRV_BOTH;
        phase_d   = PH_IDLE;
        done      = 1'b1;
      end
      PH_WAIT_LOW, PH_WAIT_HIGH: begin
        if (nib_we) begin
          miss_d = '0;
          if (idx_q == IDX_LAST) begin
            done    = 1'b1;
            pin_d   = DRV_BOTH;
            phase_d = PH_IDLE;
            idx_d   = '0;
            if (nib_cur[IDX_W'(NIB_SIG0)] != SIG0_VAL ||
                nib_cur[IDX_W'(NIB_SIG1)] != SIG1_VAL) begin
              status_d = ST_COMM_ERROR;
            end else if ((n7 & EVENT_MASK) == '0) begin
              status_d = ST_NO_EVENT;
            end else begin
              status_d = ST_KEY_EVENT;
              ev       = 1'b1;
              mb       = frame_mb;
              sc       = frame_sc;
              key_we   = 1'b1;
              key_bit  = down;
              if (mmask != '0) begin
                mod_d = down ? (mod_q | mmask) : (mod_q & ~mmask);
              end
            end
          end else begin
            idx_d = idx_q + IDX_W'(1);
            if (want) begin
              pin_d   = DRV_NONE;
              phase_d = PH_WAIT_LOW;
            end else begin
              pin_d   = DRV_TR;
              phase_d = PH_WAIT_HIGH;
            end
          end
        end else if (miss_q >= timeout_q) begin
          pin_d    = DRV_BOTH;
          phase_d  = PH_IDLE;
          status_d = ST_COMM_ERROR;
          miss_d   = '0;
          done     = 1'b1;
        end else begin
          miss_d = miss_q + TMO_W'(1);
        end
      end
      default: begin
        phase_d = PH_IDLE;
        pin_d   = DRV_BOTH;
      end
    endcase
  end

  // Stored key state of the queried scancode before this tick's update.
  always_comb begin
    if (!key_vld_q[a_q.query_scancode]) begin
      key_base = 1'b0;
    end else if (byp_vld_q && byp_addr_q == a_q.query_scancode) begin
      key_base = byp_bit_q;
    end else begin
      key_base = rd_q;
    end
  end

  always_comb begin
    res_d.th_out         = pin_d[1];
    res_d.tr_out         = pin_d[0];
    res_d.done_res       = done;
    res_d.poll_status    = status_d;
    res_d.event_valid    = ev;
    res_d.event_scancode = sc;
    res_d.make_break     = mb;
    if (clr_keys) begin
      res_d.key_pressed = 1'b0;
    end else if (key_we && sc == a_q.query_scancode) begin
      res_d.key_pressed = key_bit;
    end else begin
      res_d.key_pressed = key_base;
    end
    res_d.shift_held = |(mod_d & (MOD_LSHIFT | MOD_RSHIFT));
    res_d.ctrl_held  = |(mod_d & (MOD_LCTRL | MOD_RCTRL));
    res_d.alt_held   = |(mod_d & (MOD_LALT | MOD_RALT));
    res_d.present    = present_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TIMEOUT_RST;
      polarity_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMEOUT:  timeout_q  <= cfg_data_i[TMO_W-1:0];
        CFG_POLARITY: polarity_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline control and handshake state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      o_vld_q   <= 1'b0;
      phase_q   <= PH_IDLE;
      idx_q     <= '0;
      miss_q    <= '0;
      mod_q     <= '0;
      present_q <= 1'b0;
      status_q  <= ST_COMM_ERROR;
      pin_q     <= DRV_BOTH;
      key_vld_q <= '0;
      byp_vld_q <= 1'b0;
    end else begin
      if (load) begin
        a_vld_q   <= 1'b1;
        byp_vld_q <= commit && key_we;
      end else if (commit) begin
        a_vld_q <= 1'b0;
      end
      if (commit) begin
        o_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        o_vld_q <= 1'b0;
      end
      if (commit) begin
        phase_q   <= phase_d;
        idx_q     <= idx_d;
        miss_q    <= miss_d;
        mod_q     <= mod_d;
        present_q <= present_d;
        status_q  <= status_d;
        pin_q     <= pin_d;
        if (clr_keys) begin
          key_vld_q <= '0;
        end else if (key_we) begin
          key_vld_q[sc] <= 1'b1;
        end
      end
    end
  end

  // Payload registers and memories.
  always_ff @(posedge clk_i) begin
    if (load) begin
      a_q        <= item_t'{mode: in_ch.mode, tl_in: in_ch.tl_in, data_in: in_ch.data_in,
                            query_scancode: in_ch.query_scancode};
      rd_q       <= key_mem[in_ch.query_scancode];
      byp_addr_q <= sc;
      byp_bit_q  <= key_bit;
    end
    if (commit) begin
      res_q <= res_d;
      if (nib_we) begin
        nib_q[idx_q] <= a_q.data_in;
      end
      if (key_we) begin
        key_mem[sc] <= key_bit;
      end
    end
  end

  assign out_ch.valid          = o_vld_q;
  assign out_ch.th_out         = res_q.th_out;
  assign out_ch.tr_out         = res_q.tr_out;
  assign out_ch.done_res       = res_q.done_res;
  assign out_ch.poll_status    = res_q.poll_status;
  assign out_ch.event_valid    = res_q.event_valid;
  assign out_ch.event_scancode = res_q.event_scancode;
  assign out_ch.make_break     = res_q.make_break;
  assign out_ch.key_pressed    = res_q.key_pressed;
  assign out_ch.shift_held     = res_q.shift_held;
  assign out_ch.ctrl_held      = res_q.ctrl_held;
  assign out_ch.alt_held       = res_q.alt_held;
  assign out_ch.present        = res_q.present;

  // A reported key event always closes a poll with the key event status.
  a_event_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && res_q.event_valid) |->
      (res_q.done_res && res_q.poll_status == ST_KEY_EVENT))
    else $error("key event without a finished poll");

  // A poll frame only runs while the keyboard is known to be present.
  a_poll_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT_LOW || phase_q == PH_WAIT_HIGH) |-> present_q)
    else $error("poll running without a present keyboard");

  // Both lines are released whenever the poller is idle.
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (pin_q == DRV_BOTH))
    else $error("TH/TR not released in idle");

  // The present flag can only be raised by the end of a detect.
  a_present_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(present_q) |-> ($past(phase_q) == PH_DETECT && $past(commit)))
    else $error("present flag raised outside a detect");

endmodule
